### design/rrtp_pkg.sv
package rrtp_pkg;

    // Number of thread slots held by the block.
    localparam int unsigned MAX_THREADS = 16;
    localparam int unsigned IDX_W       = $clog2(MAX_THREADS);
    localparam int unsigned WALK_W      = $clog2(MAX_THREADS + 1);

    // Fixed field widths of the stream items.
    localparam int unsigned OPCODE_W = 3;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned TIME_W   = 64;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [TIME_W-1:0] t_time;

    typedef enum logic [OPCODE_W-1:0] {
        OP_YIELD     = 3'd0,
        OP_ADD       = 3'd1,
        OP_SLEEP     = 3'd2,
        OP_JOIN      = 3'd3,
        OP_FINISH    = 3'd4,
        OP_TERMINATE = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COUNT,
        ST_WALK,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic apply_op;
        logic free_ended;
        logic set_none;
        logic take_single;
        logic walk_init;
        logic walk_step;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_yield;
        logic count_zero;
        logic count_one;
        logic pick;
        logic walk_last;
    } t_status;

endpackage

### design/rrtp_ctrl.sv
module rrtp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output rrtp_pkg::t_cmd   o_cmd,
    input  rrtp_pkg::t_status i_status
);

    rrtp_pkg::t_state r_state;
    rrtp_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrtp_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rrtp_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = rrtp_pkg::ST_EXEC;
                end
            end
            rrtp_pkg::ST_EXEC: begin
                n_state = i_status.is_yield ? rrtp_pkg::ST_COUNT : rrtp_pkg::ST_DONE;
            end
            rrtp_pkg::ST_COUNT: begin
                if (i_status.count_zero || i_status.count_one) begin
                    n_state = rrtp_pkg::ST_DONE;
                end else begin
                    n_state = rrtp_pkg::ST_WALK;
                end
            end
            rrtp_pkg::ST_WALK: begin
                if (i_status.pick || i_status.walk_last) begin
                    n_state = rrtp_pkg::ST_DONE;
                end
            end
            rrtp_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = rrtp_pkg::ST_IDLE;
                end
            end
            default: n_state = rrtp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            rrtp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            rrtp_pkg::ST_EXEC: begin
                o_cmd.free_ended = i_status.is_yield;
                o_cmd.apply_op   = !i_status.is_yield;
            end
            rrtp_pkg::ST_COUNT: begin
                o_cmd.set_none    = i_status.count_zero;
                o_cmd.take_single = i_status.count_one;
                o_cmd.walk_init   = !i_status.count_zero && !i_status.count_one;
            end
            rrtp_pkg::ST_WALK: begin
                o_cmd.walk_step = 1'b1;
            end
            rrtp_pkg::ST_DONE: begin
                o_cmd.out_load = !r_out_valid || i_out_ready;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // The output register is refilled in the same cycle it is emptied.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### design/rrtp_datapath.sv
module rrtp_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rrtp_pkg::t_cmd       i_cmd,
    output rrtp_pkg::t_status    o_status,
    input  logic [2:0]           i_opcode,
    input  rrtp_pkg::t_slot      i_slot,
    input  rrtp_pkg::t_time      i_now_us,
    input  rrtp_pkg::t_time      i_wake_time_us,
    input  rrtp_pkg::t_slot      i_target_slot,
    output rrtp_pkg::t_slot      o_active_thread,
    output logic                 o_none_ready,
    output logic                 o_op_error
);

    localparam int unsigned N = rrtp_pkg::MAX_THREADS;

    // Captured input item.
    logic [2:0]                  r_opcode;
    rrtp_pkg::t_slot             r_slot;
    rrtp_pkg::t_time             r_now;
    rrtp_pkg::t_time             r_wake;
    rrtp_pkg::t_slot             r_target;

    // Slot table.
    logic [N-1:0]                r_valid;
    logic [N-1:0]                r_sleep;
    logic [N-1:0]                r_join;
    logic [N-1:0]                r_done;
    logic [N-1:0]                r_killed;
    rrtp_pkg::t_time             r_deadline [N];
    rrtp_pkg::t_idx              r_join_slot [N];
    rrtp_pkg::t_idx              r_active;

    // Walk state and pending result.
    rrtp_pkg::t_idx              r_walk_slot;
    logic [rrtp_pkg::WALK_W-1:0] r_walk_left;
    logic                        r_none;
    logic                        r_err;

    // Output register.
    rrtp_pkg::t_slot             r_out_active;
    logic                        r_out_none;
    logic                        r_out_err;

    rrtp_pkg::t_idx              slot_idx;
    rrtp_pkg::t_idx              tgt_idx;
    logic                        slot_in_range;
    logic                        tgt_in_range;
    logic                        named_ok;
    logic [N-1:0]                valid_less_one;
    rrtp_pkg::t_idx              single_idx;
    logic                        walk_valid;
    logic                        walk_joined;
    logic                        walk_asleep;
    logic                        target_ended;
    logic                        wake_passed;
    logic                        pass_join;
    logic                        pick;
    rrtp_pkg::t_idx              next_walk;
    rrtp_pkg::t_idx              first_walk;

    function automatic rrtp_pkg::t_idx next_idx(input rrtp_pkg::t_idx s);
        rrtp_pkg::t_idx r;
        if (32'(s) == N - 1) begin
            r = '0;
        end else begin
            r = s + rrtp_pkg::IDX_W'(1);
        end
        return r;
    endfunction

    assign slot_idx      = rrtp_pkg::IDX_W'(r_slot);
    assign tgt_idx       = rrtp_pkg::IDX_W'(r_target);
    assign slot_in_range = 32'(r_slot) < N;
    assign tgt_in_range  = 32'(r_target) < N;
    assign named_ok      = slot_in_range && r_valid[slot_idx];

    // Ended slots are already freed when the count is taken.
    assign valid_less_one = r_valid - N'(1);

    always_comb begin
        single_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (r_valid[i]) begin
                single_idx = rrtp_pkg::IDX_W'(i);
            end
        end
    end

    // After freeing, a valid target can no longer be finished or terminated.
    assign walk_valid   = r_valid[r_walk_slot];
    assign walk_joined  = r_join[r_walk_slot];
    assign walk_asleep  = r_sleep[r_walk_slot];
    assign target_ended = !r_valid[r_join_slot[r_walk_slot]];
    assign wake_passed  = r_deadline[r_walk_slot] <= r_now;
    assign pass_join    = !walk_joined || target_ended;
    assign pick         = walk_valid && pass_join && (!walk_asleep || wake_passed);
    assign next_walk    = next_idx(r_walk_slot);
    assign first_walk   = next_idx(r_active);

    assign o_status.is_yield   = r_opcode == rrtp_pkg::OP_YIELD;
    assign o_status.count_zero = r_valid == '0;
    assign o_status.count_one  = (r_valid != '0) && ((r_valid & valid_less_one) == '0);
    assign o_status.pick       = pick;
    assign o_status.walk_last  = r_walk_left == rrtp_pkg::WALK_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_opcode <= i_opcode;
            r_slot   <= i_slot;
            r_now    <= i_now_us;
            r_wake   <= i_wake_time_us;
            r_target <= i_target_slot;
        end
        if (i_cmd.apply_op && named_ok) begin
            if (r_opcode == rrtp_pkg::OP_SLEEP) begin
                r_deadline[slot_idx] <= r_wake;
            end
            if (r_opcode == rrtp_pkg::OP_JOIN && tgt_in_range) begin
                r_join_slot[slot_idx] <= tgt_idx;
            end
        end
        if (i_cmd.walk_init) begin
            r_walk_slot <= first_walk;
            r_walk_left <= rrtp_pkg::WALK_W'(N);
        end else if (i_cmd.walk_step) begin
            r_walk_slot <= next_walk;
            r_walk_left <= r_walk_left - rrtp_pkg::WALK_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_active <= rrtp_pkg::SLOT_W'(r_active);
            r_out_none   <= r_none;
            r_out_err    <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_sleep  <= '0;
            r_join   <= '0;
            r_done   <= '0;
            r_killed <= '0;
            r_active <= '0;
            r_none   <= 1'b0;
            r_err    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_none <= 1'b0;
                r_err  <= 1'b0;
            end
            if (i_cmd.apply_op) begin
                unique case (r_opcode)
                    rrtp_pkg::OP_ADD: begin
                        if (!slot_in_range || r_valid[slot_idx]) begin
                            r_err <= 1'b1;
                        end else begin
                            r_valid[slot_idx]  <= 1'b1;
                            r_sleep[slot_idx]  <= 1'b0;
                            r_join[slot_idx]   <= 1'b0;
                            r_done[slot_idx]   <= 1'b0;
                            r_killed[slot_idx] <= 1'b0;
                        end
                    end
                    rrtp_pkg::OP_SLEEP: begin
                        if (!named_ok) begin
                            r_err <= 1'b1;
                        end else begin
                            r_sleep[slot_idx] <= 1'b1;
                        end
                    end
                    rrtp_pkg::OP_JOIN: begin
                        if (!named_ok || !tgt_in_range) begin
                            r_err <= 1'b1;
                        end else begin
                            r_join[slot_idx] <= 1'b1;
                        end
                    end
                    rrtp_pkg::OP_FINISH: begin
                        if (!named_ok) begin
                            r_err <= 1'b1;
                        end else begin
                            r_done[slot_idx] <= 1'b1;
                        end
                    end
                    rrtp_pkg::OP_TERMINATE: begin
                        if (!named_ok) begin
                            r_err <= 1'b1;
                        end else begin
                            r_killed[slot_idx] <= 1'b1;
                        end
                    end
                    default: r_err <= 1'b1;
                endcase
            end
            if (i_cmd.free_ended) begin
                for (int i = 0; i < N; i++) begin
                    if (r_valid[i] && (r_done[i] || r_killed[i])) begin
                        r_valid[i]  <= 1'b0;
                        r_sleep[i]  <= 1'b0;
                        r_join[i]   <= 1'b0;
                        r_done[i]   <= 1'b0;
                        r_killed[i] <= 1'b0;
                    end
                end
            end
            if (i_cmd.set_none) begin
                r_none <= 1'b1;
            end
            if (i_cmd.take_single) begin
                r_active <= single_idx;
            end
            if (i_cmd.walk_step) begin
                // Flags released on the way stay released even when the slot is skipped.
                if (walk_valid && walk_joined && target_ended) begin
                    r_join[r_walk_slot] <= 1'b0;
                end
                if (walk_valid && pass_join && walk_asleep && wake_passed) begin
                    r_sleep[r_walk_slot] <= 1'b0;
                end
                if (pick) begin
                    r_active <= r_walk_slot;
                end else if (r_walk_left == rrtp_pkg::WALK_W'(1)) begin
                    r_none <= 1'b1;
                end
            end
        end
    end

    assign o_active_thread = r_out_active;
    assign o_none_ready    = r_out_none;
    assign o_op_error      = r_out_err;

endmodule

### design/round_robin_thread_picker.sv
// Round-robin thread picker. Each input transfer carries one command (yield, add, sleep,
// join, finish, terminate) and produces exactly one output transfer with the active
// thread slot, a none-ready flag and an error flag. Commands other than yield go
// from the execute state to the done state, which loads the output register. A yield
// frees ended threads and counts the rest; with zero or one left it goes to the done
// state, else the scan visits up to MAX_THREADS slots, one per cycle after the active
// one, halting at the first runnable slot. One command is processed at a time; a finished
// result waits in an output register so the next command can start before it is taken.
module round_robin_thread_picker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // tdata: slot[3:0], now_us[67:4], wake_time_us[131:68], target_slot[135:132]
    input  logic [135:0]  i_s_axis_tdata,
    // tuser: opcode[2:0]
    input  logic [2:0]    i_s_axis_tuser,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // tdata: active_thread[3:0], zero fill[7:4]
    output logic [7:0]    o_m_axis_tdata,
    // tuser: none_ready[0], op_error[1]
    output logic [1:0]    o_m_axis_tuser
);

    rrtp_pkg::t_cmd    cmd;
    rrtp_pkg::t_status status;
    rrtp_pkg::t_slot   active_thread;
    logic              none_ready;
    logic              op_error;

    rrtp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    rrtp_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_opcode        (i_s_axis_tuser),
        .i_slot          (i_s_axis_tdata[3:0]),
        .i_now_us        (i_s_axis_tdata[67:4]),
        .i_wake_time_us  (i_s_axis_tdata[131:68]),
        .i_target_slot   (i_s_axis_tdata[135:132]),
        .o_active_thread (active_thread),
        .o_none_ready    (none_ready),
        .o_op_error      (op_error)
    );

    assign o_m_axis_tdata = {4'b0000, active_thread};
    assign o_m_axis_tuser = {op_error, none_ready};

endmodule

### dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Opcodes outside the defined set; the block must reject them.
    localparam logic [rrtp_pkg::OPCODE_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [rrtp_pkg::OPCODE_W-1:0] OP_RSVD7 = 3'd7;

    localparam int unsigned    RANDOM_ITEMS = 730;
    localparam int unsigned    STALL_LIMIT  = 3000;
    localparam int unsigned    TAIL_CYCLES  = 40;
    localparam rrtp_pkg::t_time TIME_MAX    = '1;

    typedef struct {
        logic [rrtp_pkg::OPCODE_W-1:0] opcode;
        rrtp_pkg::t_slot               slot;
        rrtp_pkg::t_time               now_us;
        rrtp_pkg::t_time               wake_us;
        rrtp_pkg::t_slot               target;
    } t_sched_req;

    typedef struct {
        rrtp_pkg::t_slot active;
        logic            none_ready;
        logic            op_error;
    } t_sched_resp;

    typedef struct {
        t_sched_req  req;
        bit          typed;
        t_sched_resp resp;
    } t_directed_row;

    logic          i_clk    = 1'b0;
    logic          rst_n    = 1'b0;
    logic          s_tvalid = 1'b0;
    logic [135:0]  s_tdata  = '0;
    logic [2:0]    s_tuser  = '0;
    logic          m_tready = 1'b0;
    logic          s_tready;
    logic          m_tvalid;
    logic [7:0]    m_tdata;
    logic [1:0]    m_tuser;

    round_robin_thread_picker u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the thread table.
    bit              thr_valid    [rrtp_pkg::MAX_THREADS];
    bit              thr_sleep    [rrtp_pkg::MAX_THREADS];
    bit              thr_join     [rrtp_pkg::MAX_THREADS];
    bit              thr_done     [rrtp_pkg::MAX_THREADS];
    bit              thr_killed   [rrtp_pkg::MAX_THREADS];
    rrtp_pkg::t_time thr_deadline [rrtp_pkg::MAX_THREADS];
    rrtp_pkg::t_slot thr_target   [rrtp_pkg::MAX_THREADS];
    rrtp_pkg::t_slot cur_slot = '0;

    t_sched_resp   pending_resp_q[$];
    t_directed_row directed_tbl[$];

    int unsigned     src_idle_pct = 7;
    int unsigned     snk_idle_pct = 62;
    int unsigned     mismatch_cnt = 0;
    int unsigned     sent_cnt     = 0;
    int unsigned     none_cnt     = 0;
    int unsigned     reject_cnt   = 0;
    int unsigned     stall_cycles = 0;
    rrtp_pkg::t_time sim_now      = '0;

    function automatic void clear_thread(int unsigned s);
        thr_valid[s]  = 1'b0;
        thr_sleep[s]  = 1'b0;
        thr_join[s]   = 1'b0;
        thr_done[s]   = 1'b0;
        thr_killed[s] = 1'b0;
    endfunction

    // Applies one command to the shadow table and returns the result it causes.
    function automatic t_sched_resp predict_schedule(t_sched_req r);
        t_sched_resp     res;
        bit              named_ok;
        bit              found;
        int unsigned     live;
        int unsigned     last_live;
        int unsigned     s;
        rrtp_pkg::t_slot tgt;
        res.none_ready = 1'b0;
        res.op_error   = 1'b0;
        named_ok       = thr_valid[r.slot];
        case (r.opcode)
            rrtp_pkg::OP_YIELD: begin
                live      = 0;
                last_live = 0;
                for (int i = 0; i < rrtp_pkg::MAX_THREADS; i++) begin
                    if (thr_valid[i] && (thr_done[i] || thr_killed[i]))
                        clear_thread(i);
                    if (thr_valid[i]) begin
                        live++;
                        last_live = i;
                    end
                end
                if (live == 0) begin
                    res.none_ready = 1'b1;
                end else if (live == 1) begin
                    // A lone thread runs even if it is asleep or joined.
                    cur_slot = rrtp_pkg::t_slot'(last_live);
                end else begin
                    found = 1'b0;
                    for (int k = 1; k <= rrtp_pkg::MAX_THREADS && !found; k++) begin
                        s = (int'(cur_slot) + k) % rrtp_pkg::MAX_THREADS;
                        if (thr_valid[s]) begin
                            found = 1'b1;
                            if (thr_join[s]) begin
                                tgt = thr_target[s];
                                if (!thr_valid[tgt] || thr_done[tgt] || thr_killed[tgt])
                                    thr_join[s] = 1'b0;
                                else
                                    found = 1'b0;
                            end
                            if (found && thr_sleep[s]) begin
                                if (thr_deadline[s] <= r.now_us)
                                    thr_sleep[s] = 1'b0;
                                else
                                    found = 1'b0;
                            end
                            if (found)
                                cur_slot = rrtp_pkg::t_slot'(s);
                        end
                    end
                    res.none_ready = !found;
                end
            end
            rrtp_pkg::OP_ADD: begin
                if (thr_valid[r.slot]) begin
                    res.op_error = 1'b1;
                end else begin
                    clear_thread(r.slot);
                    thr_valid[r.slot] = 1'b1;
                end
            end
            rrtp_pkg::OP_SLEEP: begin
                if (!named_ok) begin
                    res.op_error = 1'b1;
                end else begin
                    thr_sleep[r.slot]    = 1'b1;
                    thr_deadline[r.slot] = r.wake_us;
                end
            end
            rrtp_pkg::OP_JOIN: begin
                if (!named_ok) begin
                    res.op_error = 1'b1;
                end else begin
                    thr_join[r.slot]   = 1'b1;
                    thr_target[r.slot] = r.target;
                end
            end
            rrtp_pkg::OP_FINISH: begin
                if (!named_ok) res.op_error = 1'b1;
                else thr_done[r.slot] = 1'b1;
            end
            rrtp_pkg::OP_TERMINATE: begin
                if (!named_ok) res.op_error = 1'b1;
                else thr_killed[r.slot] = 1'b1;
            end
            default: res.op_error = 1'b1;
        endcase
        res.active = cur_slot;
        return res;
    endfunction

    function automatic rrtp_pkg::t_slot pick_slot(bit want_valid);
        rrtp_pkg::t_slot pool[$];
        for (int i = 0; i < rrtp_pkg::MAX_THREADS; i++)
            if (thr_valid[i] == want_valid) pool.push_back(rrtp_pkg::t_slot'(i));
        if (pool.size() == 0)
            return rrtp_pkg::t_slot'($urandom_range(rrtp_pkg::MAX_THREADS - 1));
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    // Mostly commands on live threads with times near the running clock, some noise.
    function automatic t_sched_req gen_command();
        t_sched_req  r;
        int unsigned w;
        int unsigned live;
        int unsigned add_band;
        live = 0;
        foreach (thr_valid[i]) if (thr_valid[i]) live++;
        sim_now   += rrtp_pkg::t_time'($urandom_range(40));
        r.slot    = rrtp_pkg::t_slot'($urandom_range(rrtp_pkg::MAX_THREADS - 1));
        r.target  = rrtp_pkg::t_slot'($urandom_range(rrtp_pkg::MAX_THREADS - 1));
        r.now_us  = {$urandom, $urandom};
        r.wake_us = {$urandom, $urandom};
        add_band  = (live < 12) ? 22 : 6;
        w = $urandom_range(99);
        if (w < 3) begin
            r.opcode = $urandom_range(1) ? OP_RSVD6 : OP_RSVD7;
        end else if (w < 33) begin
            r.opcode = rrtp_pkg::OP_YIELD;
            if ($urandom_range(19) != 0) r.now_us = sim_now;
        end else if (w < 33 + add_band) begin
            r.opcode = rrtp_pkg::OP_ADD;
            if ($urandom_range(9) != 0) r.slot = pick_slot(1'b0);
        end else begin
            w = $urandom_range(99);
            if (w < 35)      r.opcode = rrtp_pkg::OP_SLEEP;
            else if (w < 65) r.opcode = rrtp_pkg::OP_JOIN;
            else if (w < 82) r.opcode = rrtp_pkg::OP_FINISH;
            else             r.opcode = rrtp_pkg::OP_TERMINATE;
            if ($urandom_range(9) != 0) r.slot = pick_slot(1'b1);
            if ($urandom_range(3) != 0) r.target = pick_slot(1'b1);
            w = $urandom_range(99);
            if (w < 3)       r.wake_us = $urandom_range(1) ? TIME_MAX : '0;
            else if (w < 92) r.wake_us = sim_now + rrtp_pkg::t_time'($urandom_range(150));
        end
        return r;
    endfunction

    task automatic add_row(input logic [rrtp_pkg::OPCODE_W-1:0] op,
                           input rrtp_pkg::t_slot s, input rrtp_pkg::t_time now,
                           input rrtp_pkg::t_time wake, input rrtp_pkg::t_slot tgt,
                           input bit typed, input rrtp_pkg::t_slot act,
                           input logic none, input logic err);
        t_directed_row row;
        row.req.opcode       = op;
        row.req.slot         = s;
        row.req.now_us       = now;
        row.req.wake_us      = wake;
        row.req.target       = tgt;
        row.typed            = typed;
        row.resp.active      = act;
        row.resp.none_ready  = none;
        row.resp.op_error    = err;
        directed_tbl.push_back(row);
    endtask

    // The expectation is queued at the edge where the transfer is taken.
    task automatic send_command(input t_sched_req r, input bit typed, input t_sched_resp fixed);
        t_sched_resp pred;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.target, r.wake_us, r.now_us, r.slot};
        s_tuser  <= r.opcode;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        pred = predict_schedule(r);
        if (typed)
            pending_resp_q.push_back(fixed);
        else
            pending_resp_q.push_back(pred);
        sent_cnt++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_resp_q.size() != 0);
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_sched_resp exp_r;
        t_sched_resp got_r;
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
        if (rst_n && m_tvalid && m_tready) begin
            got_r.active     = m_tdata[3:0];
            got_r.none_ready = m_tuser[0];
            got_r.op_error   = m_tuser[1];
            if (got_r.none_ready) none_cnt++;
            if (got_r.op_error) reject_cnt++;
            if (pending_resp_q.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("%t: result with nothing pending: active=%0d none=%b err=%b",
                             $realtime, got_r.active, got_r.none_ready, got_r.op_error);
                mismatch_cnt++;
            end else begin
                exp_r = pending_resp_q.pop_front();
                if (got_r.active !== exp_r.active || got_r.none_ready !== exp_r.none_ready ||
                    got_r.op_error !== exp_r.op_error) begin
                    if (mismatch_cnt < 10) begin
                        $display("%t: mismatch: expected active=%0d none=%b err=%b,",
                                 $realtime, exp_r.active, exp_r.none_ready, exp_r.op_error);
                        $display("    got active=%0d none=%b err=%b",
                                 got_r.active, got_r.none_ready, got_r.op_error);
                    end
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("No transfer for %0d cycles, %0d results still pending.",
                         STALL_LIMIT, pending_resp_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_sched_resp no_resp;
        t_sched_req  cmd;
        no_resp = '{default: '0};

        // After reset: nothing to run, empty slots and a repeated add rejected, reserved opcodes rejected.
        add_row(rrtp_pkg::OP_YIELD,     4'd0,  '0,       '0,       4'd0,  1, 4'd0, 1'b1, 1'b0);
        add_row(rrtp_pkg::OP_SLEEP,     4'd3,  '0,       TIME_MAX, 4'd0,  1, 4'd0, 1'b0, 1'b1);
        add_row(rrtp_pkg::OP_ADD,       4'd0,  '0,       '0,       4'd0,  0, 4'd0, 1'b0, 1'b0);
        add_row(rrtp_pkg::OP_ADD,       4'd0,  TIME_MAX, TIME_MAX, 4'd15, 1, 4'd0, 1'b0, 1'b1);
        add_row(rrtp_pkg::OP_ADD,       4'd15, '0,       '0,       4'd0,  0, 4'd0, 1'b0, 1'b0);
        add_row(OP_RSVD6,               4'd15, TIME_MAX, TIME_MAX, 4'd15, 1, 4'd0, 1'b0, 1'b1);
        add_row(OP_RSVD7,               4'd0,  '0,       '0,       4'd0,  1, 4'd0, 1'b0, 1'b1);
        add_row(rrtp_pkg::OP_YIELD,     4'd15, TIME_MAX, '0,       4'd15, 0, 4'd0, 1'b0, 1'b0);
        // Sleeper with the latest deadline: skipped at time zero, woken at the maximum time.
        add_row(rrtp_pkg::OP_SLEEP,     4'd0,  '0,       TIME_MAX, 4'd0,  0, 4'd0, 1'b0, 1'b0);
        add_row(rrtp_pkg::OP_YIELD,     4'd0,  '0,       '0,       4'd0,  0, 4'd0, 1'b0, 1'b0);
        add_row(rrtp_pkg::OP_JOIN,      4'd15, '0,       '0,       4'd0,  0, 4'd0, 1'b0, 1'b0);
        add_row(rrtp_pkg::OP_YIELD,     4'd0,  TIME_MAX, '0,       4'd0,  0, 4'd0, 1'b0, 1'b0);
        // Two threads waiting on each other: none ready, active slot kept.
        add_row(rrtp_pkg::OP_JOIN,      4'd0,  '0,       '0,       4'd15, 0, 4'd0, 1'b0, 1'b0);
        add_row(rrtp_pkg::OP_YIELD,     4'd0,  TIME_MAX, '0,       4'd0,  0, 4'd0, 1'b0, 1'b0);
        // Finished thread freed; the lone joined thread runs anyway.
        add_row(rrtp_pkg::OP_FINISH,    4'd0,  '0,       '0,       4'd0,  0, 4'd0, 1'b0, 1'b0);
        add_row(rrtp_pkg::OP_YIELD,     4'd0,  '0,       '0,       4'd0,  0, 4'd0, 1'b0, 1'b0);
        // Join to an empty target is accepted.
        add_row(rrtp_pkg::OP_JOIN,      4'd15, '0,       '0,       4'd7,  0, 4'd0, 1'b0, 1'b0);
        add_row(rrtp_pkg::OP_ADD,       4'd7,  '0,       '0,       4'd0,  0, 4'd0, 1'b0, 1'b0);
        add_row(rrtp_pkg::OP_YIELD,     4'd0,  '0,       '0,       4'd0,  0, 4'd0, 1'b0, 1'b0);
        add_row(rrtp_pkg::OP_TERMINATE, 4'd7,  '0,       '0,       4'd0,  0, 4'd0, 1'b0, 1'b0);
        add_row(rrtp_pkg::OP_FINISH,    4'd4,  '0,       '0,       4'd0,  1, 4'd7, 1'b0, 1'b1);
        add_row(rrtp_pkg::OP_TERMINATE, 4'd9,  '0,       '0,       4'd0,  1, 4'd7, 1'b0, 1'b1);
        add_row(rrtp_pkg::OP_YIELD,     4'd0,  '0,       '0,       4'd0,  0, 4'd0, 1'b0, 1'b0);
        add_row(rrtp_pkg::OP_SLEEP,     4'd15, '0,       '0,       4'd0,  0, 4'd0, 1'b0, 1'b0);
        add_row(rrtp_pkg::OP_TERMINATE, 4'd15, '0,       '0,       4'd0,  0, 4'd0, 1'b0, 1'b0);
        add_row(rrtp_pkg::OP_YIELD,     4'd0,  '0,       '0,       4'd0,  0, 4'd0, 1'b0, 1'b0);

        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_tbl[i])
            send_command(directed_tbl[i].req, directed_tbl[i].typed, directed_tbl[i].resp);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                wait_drained();
                src_idle_pct = 62;
                snk_idle_pct = 7;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                wait_drained();
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else if ($urandom_range(199) == 0) begin
                wait_drained();
            end
            cmd = gen_command();
            send_command(cmd, 1'b0, no_resp);
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d commands (%0d directed) over three idle patterns.",
                 sent_cnt, directed_tbl.size());
        $display("Seen %0d none-ready yields and %0d rejected commands; %0d mismatches.",
                 none_cnt, reject_cnt, mismatch_cnt);
        if (mismatch_cnt == 0 && pending_resp_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
design/rrtp_pkg.sv
design/rrtp_ctrl.sv
design/rrtp_datapath.sv
design/round_robin_thread_picker.sv
dv/tb_top.sv
